// ===== hw/rtl/fat_block_cache_directory_core_macros.svh =====
// ----------------------------------------------------------------------------
// fat block cache directory assertion macros
// shared concurrent assertion forms for the directory rtl
// ----------------------------------------------------------------------------
`ifndef FAT_BLOCK_CACHE_DIRECTORY_CORE_MACROS_SVH
`define FAT_BLOCK_CACHE_DIRECTORY_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FBCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define FBCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcd_pkg
// types, sizes and helper functions of the block cache directory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbcd_pkg;

   localparam int SLOTS     = 8;
   localparam int TAG_BITS  = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FLUSH = 2'd2,
      ACT_INVAL = 2'd3
   } fbcd_action_type;

   typedef struct packed {
      fbcd_action_type     action;
      logic [TAG_BITS-1:0] block_tag;
   } fbcd_req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic                 hit;
      logic                 fill;
      logic                 writeback;
      logic [TAG_BITS-1:0]  old_tag;
      logic                 dirty_lost;
      logic                 status;
      logic                 last;
   } fbcd_rsp_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] idx;
   } fbcd_find_type;

   // slot search results handed from the selector to the directory
   typedef struct packed {
      fbcd_find_type        hit;
      fbcd_find_type        free;
      fbcd_find_type        clean;
      fbcd_find_type        dirty;
      logic                 dirty_more;
   } fbcd_pick_type;

   // lowest set bit of a slot vector
   function automatic fbcd_find_type find_first(input logic [SLOTS-1:0] vec);
      fbcd_find_type res;
      res.found = |vec;
      res.idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res.idx = SLOT_BITS'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/fbcd_select.sv =====
// ----------------------------------------------------------------------------
// fbcd_select
// parallel tag match and priority searches over all cache slots
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbcd_select
   import fbcd_pkg::*;
(
   input  logic [SLOTS-1:0]               valid,
   input  logic [SLOTS-1:0]               dirty,
   input  logic [SLOTS-1:0][TAG_BITS-1:0] tags,
   input  logic [TAG_BITS-1:0]            tag,
   input  logic [SLOT_BITS-1:0]           rot,
   output fbcd_pick_type                  pick
);

   logic [SLOTS-1:0] match;
   logic [SLOTS-1:0] clean;
   logic [SLOTS-1:0] clean_up;
   fbcd_find_type    clean_hi;
   fbcd_find_type    clean_lo;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i]    = valid[i] && (tags[i] == tag);
         clean[i]    = !dirty[i];
         // clean slots at or after the rotating index
         clean_up[i] = !dirty[i] && (SLOT_BITS'(i) >= rot);
      end
   end

   assign clean_hi = find_first(clean_up);
   assign clean_lo = find_first(clean);

   always_comb begin
      pick.hit        = find_first(match);
      pick.free       = find_first(~valid);
      pick.clean      = clean_hi.found ? clean_hi : clean_lo;
      pick.dirty      = find_first(dirty);
      // clearing the lowest set bit leaves the other dirty slots
      pick.dirty_more = |(dirty & (dirty - SLOTS'(1)));
   end

endmodule

// ===== hw/rtl/fbcd_dir.sv =====
// ----------------------------------------------------------------------------
// fbcd_dir
// slot state of the directory and the per-transaction update decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbcd_dir
   import fbcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         exec,
   input  logic         write_lock,
   input  fbcd_req_type item,
   output fbcd_rsp_type res
);

   logic [SLOTS-1:0][TAG_BITS-1:0] tags_ff;
   logic [SLOTS-1:0]               valid_ff;
   logic [SLOTS-1:0]               valid_in;
   logic [SLOTS-1:0]               dirty_ff;
   logic [SLOTS-1:0]               dirty_in;
   logic [SLOT_BITS-1:0]           rot_ff;
   logic [SLOT_BITS-1:0]           rot_in;
   logic [SLOT_BITS-1:0]           rot_nxt;
   logic [SLOT_BITS-1:0]           chosen;
   logic [SLOT_BITS-1:0]           rd_idx;
   logic [TAG_BITS-1:0]            rd_tag;
   logic                           tag_we;
   fbcd_pick_type                  pick;

   assign rot_nxt = (rot_ff == SLOT_BITS'(SLOTS - 1)) ? '0 : rot_ff + SLOT_BITS'(1);

   fbcd_select u_select (
      .valid (valid_ff),
      .dirty (dirty_ff),
      .tags  (tags_ff),
      .tag   (item.block_tag),
      .rot   (rot_nxt),
      .pick  (pick)
   );

   // single tag read port: flush victim or rotating victim
   assign rd_idx = (item.action == ACT_FLUSH) ? pick.dirty.idx : rot_nxt;
   assign rd_tag = tags_ff[rd_idx];

   always_comb begin
      res      = '0;
      res.last = 1'b1;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rot_in   = rot_ff;
      tag_we   = 1'b0;
      chosen   = rot_nxt;
      case (item.action)
         ACT_INVAL: begin
            valid_in = '0;
            dirty_in = '0;
         end
         ACT_FLUSH: begin
            if (write_lock) begin
               res.status = 1'b1;
            end else if (pick.dirty.found) begin
               res.slot                  = pick.dirty.idx;
               res.writeback             = 1'b1;
               res.old_tag               = rd_tag;
               res.last                  = !pick.dirty_more;
               dirty_in[pick.dirty.idx]  = 1'b0;
            end
         end
         ACT_READ, ACT_WRITE: begin
            if (item.action == ACT_WRITE && write_lock) begin
               res.status = 1'b1;
            end else begin
               rot_in = rot_nxt;
               if (pick.hit.found) begin
                  chosen = pick.hit.idx;
               end else if (pick.free.found) begin
                  chosen = pick.free.idx;
               end else if (pick.clean.found && !rot_nxt[0]) begin
                  chosen = pick.clean.idx;
               end else if (dirty_ff[rot_nxt]) begin
                  // dirty victim at the rotating index
                  res.old_tag    = rd_tag;
                  res.dirty_lost = write_lock;
                  res.writeback  = !write_lock;
               end
               res.slot = chosen;
               res.hit  = pick.hit.found;
               res.fill = !pick.hit.found;
               if (!pick.hit.found) begin
                  tag_we           = 1'b1;
                  valid_in[chosen] = 1'b1;
                  dirty_in[chosen] = 1'b0;
               end
               if (item.action == ACT_WRITE) begin
                  dirty_in[chosen] = 1'b1;
               end
            end
         end
         default: begin
            res.last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         rot_ff   <= '0;
      end else if (exec) begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rot_ff   <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec && tag_we) begin
         tags_ff[chosen] <= item.block_tag;
      end
   end

endmodule

// ===== hw/rtl/fat_block_cache_directory_core.sv =====
// ----------------------------------------------------------------------------
// fat_block_cache_directory_core
// directory of a small fully associative write-back cache of table blocks
// ----------------------------------------------------------------------------
// usage:
//   req_valid/req_ready/req_data carry an access, flush or invalidate
//   transaction; rsp_valid/rsp_ready/rsp_data return its results, the final
//   one with last set. csr_we/csr_wdata write the read-only mode bit; the user
//   must write it only while the block is idle, which the block does not enforce.
// order: an accepted transaction is held in the input register, decided from it
//   combinationally, and its result is then captured in the result register.
// throughput: one read, write or invalidate per cycle while rsp_ready stays high.
//   a flush holds the input register until its last dirty slot is reported,
//   loading one result per dirty slot (at least one) into the single result register.
// reset: all slots become invalid and clean, the rotating index goes to zero
//   and read-only mode is off; slot tags are left as they are.
// stall: while rsp_ready is low the result register holds its transaction,
//   the input register still takes one more request, and req_ready then
//   stays low until the result moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_block_cache_directory_core
   import fbcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  fbcd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output fbcd_rsp_type rsp_data
);

   `include "fat_block_cache_directory_core_macros.svh"

   logic         write_lock_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   fbcd_req_type in_data_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   fbcd_rsp_type rsp_data_ff;
   fbcd_rsp_type res;
   logic         exec;
   logic         accept;

   fbcd_dir u_dir (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .write_lock (write_lock_ff),
      .item       (in_data_ff),
      .res        (res)
   );

   assign exec      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || (exec && res.last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (exec && res.last) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_lock_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            write_lock_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (exec) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FBCD_ASSERT_NXT(a_flush_holds, clock, reset, exec && !res.last, in_valid_ff && (in_data_ff.action == ACT_FLUSH), "unfinished flush left the input register")
   `FBCD_ASSERT_IMP(a_refused_last, clock, reset, rsp_valid_ff && rsp_data_ff.status, rsp_data_ff.last && !rsp_data_ff.writeback, "refused transaction with extra results")
   `FBCD_ASSERT_IMP(a_wb_not_lost, clock, reset, rsp_valid_ff && rsp_data_ff.writeback, !rsp_data_ff.dirty_lost && !rsp_data_ff.hit, "writeback flagged with drop or hit")
   `FBCD_ASSERT_IMP(a_lost_ro, clock, reset, rsp_valid_ff && rsp_data_ff.dirty_lost, write_lock_ff && rsp_data_ff.fill, "dirty drop outside read-only miss")

endmodule
